// File: rtl/core/ins_sort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_sort_pkg
// Shared constants, types and state encoding for the insertion sorter.
// ----------------------------------------------------------------------------
package ins_sort_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic pop;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

// File: rtl/core/ins_sort_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_sort_in_if
// Input channel: one element of a set per transaction.
// ----------------------------------------------------------------------------
interface ins_sort_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value;
  logic                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/core/ins_sort_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_sort_out_if
// Output channel: one sorted element per transaction.
// ----------------------------------------------------------------------------
interface ins_sort_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  sorted_value;
  logic                end_of_set;
  logic                overflowed;

  modport source (output valid, output sorted_value, output end_of_set,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set,
                  input overflowed, output ready);
endinterface

// File: rtl/core/ins_sort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_sort_ctrl
// Load/emit sequencer: gates the input while a sorted set drains out.
// ----------------------------------------------------------------------------
module ins_sort_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_last,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  ins_sort_pkg::status_t status,
  output ins_sort_pkg::cmd_t    cmd
);
  import ins_sort_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (item_valid && item_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (result_ready && status.last_one) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_LOAD: item_ready   = 1'b1;
      ST_EMIT: result_valid = 1'b1;
      default: ;
    endcase
    cmd.insert = item_valid && item_ready;
    cmd.pop    = result_valid && result_ready;
  end

endmodule

// File: rtl/core/ins_sort_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_sort_datapath
// Systolic cell row: parallel compare-and-shift insert, shift-down drain.
// ----------------------------------------------------------------------------
module ins_sort_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ins_sort_pkg::cmd_t    cmd,
  input  ins_sort_pkg::value_t  value,
  output ins_sort_pkg::status_t status,
  output ins_sort_pkg::value_t  sorted_value,
  output logic                  end_of_set,
  output logic                  overflowed
);
  import ins_sort_pkg::*;

  value_t       cells [DEPTH];
  value_t       cells_next [DEPTH];
  logic [DEPTH-1:0] above;   // cell is empty or holds a value greater than the new one
  count_t       fill;
  logic         overflow_seen;
  logic         full;

  assign full = (fill == count_t'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      above[i] = (count_t'(i) >= fill) || (cells[i] > value);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.pop) begin
        cells_next[i] = (i < DEPTH - 1) ? cells[(i < DEPTH - 1) ? i + 1 : i] : cells[i];
      end else if (above[i]) begin
        // first cell above takes the new value, the rest shift up by one
        cells_next[i] = (i > 0 && above[(i > 0) ? i - 1 : 0]) ? cells[(i > 0) ? i - 1 : 0]
                                                              : value;
      end else begin
        cells_next[i] = cells[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop || (cmd.insert && !full)) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.pop) begin
      fill <= fill - count_t'(1);
      if (fill == count_t'(1)) overflow_seen <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        fill <= fill + count_t'(1);
      end
    end
  end

  assign status.last_one = (fill == count_t'(1));
  assign sorted_value    = cells[0];
  assign end_of_set      = status.last_one;
  assign overflowed      = overflow_seen;

endmodule

// File: rtl/core/insertion_sorter_core.sv
`timescale 1ns / 1ps
// Insertion sorter: one element accepted per cycle while loading; each element is
// placed in the same cycle by a compare-and-shift across all cells of the row.
// The first sorted result is valid the cycle after the last element is taken, then
// one result per unstalled cycle; a set of n elements drains as min(n, 16) results.
// Input is held off while a set drains. Reset (rst, synchronous) clears the fill
// count, the overflow flag and the sequencer; cell contents are not cleared.
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Top level: sequencer plus cell-row datapath behind two stream channels.
// ----------------------------------------------------------------------------
module insertion_sorter_core (
  input logic       clk,
  input logic       rst,
  ins_sort_in_if.sink    item,
  ins_sort_out_if.source result
);
  import ins_sort_pkg::*;

  cmd_t    cmd;
  status_t status;
  value_t  sorted_value;

  ins_sort_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_last    (item.last),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  ins_sort_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (item.value),
    .status       (status),
    .sorted_value (sorted_value),
    .end_of_set   (result.end_of_set),
    .overflowed   (result.overflowed)
  );

  assign result.sorted_value = sorted_value;

endmodule
